// ===== rtl/core/cbo_pkg.sv =====
`default_nettype none

package cbo_pkg;

    localparam int BADGE_W_DEFAULT = 72;
    localparam int BADGE_H_DEFAULT = 32;

    localparam int COORD_W    = 13;
    localparam int CHAN_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SKIP_BADGE   = 2'd2
    } cfg_index_t;

    localparam int MARGIN    = 16;
    localparam int BAR_W     = 6;
    localparam int BAR_H     = 12;
    localparam int BAR_Y_OFS = 6;
    localparam int BAR0_X    = 18;
    localparam int BAR1_X    = 34;
    localparam int BAR2_X    = 50;

    localparam logic [CHAN_W-1:0] BG_ALPHA  = 8'd150;
    localparam logic [CHAN_W-1:0] BAR_ALPHA = 8'd200;

    // gradient end points, orange on the left, purple on the right
    localparam logic [CHAN_W-1:0] RED_LEFT  = 8'hFF;
    localparam logic [CHAN_W-1:0] RED_RIGHT = 8'h9D;
    localparam logic [CHAN_W-1:0] GRN_LEFT  = 8'h5A;
    localparam logic [CHAN_W-1:0] GRN_RIGHT = 8'h4E;
    localparam logic [CHAN_W-1:0] BLU_LEFT  = 8'h3C;
    localparam logic [CHAN_W-1:0] BLU_RIGHT = 8'hDD;

    localparam logic [CHAN_W-1:0] BAR_RED = 8'd245;
    localparam logic [CHAN_W-1:0] BAR_GRN = 8'd245;
    localparam logic [CHAN_W-1:0] BAR_BLU = 8'd250;

    // pipeline stage positions
    localparam int NUM_STAGES    = 9;
    localparam int STG_LOC_A     = 0;
    localparam int STG_LOC_B     = 1;
    localparam int STG_RAMP_NUM  = 2;
    localparam int STG_RAMP_PROD = 3;
    localparam int STG_RAMP_FIX  = 4;
    localparam int STG_MIX1_SUM  = 5;
    localparam int STG_MIX1_DIV  = 6;
    localparam int STG_MIX2_SUM  = 7;
    localparam int STG_MIX2_DIV  = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t              pix;
        logic [CHAN_W-1:0] alpha;
        logic              in_badge;
        logic              in_bar;
    } side_t;

    // exact floor(x / 255) for any 16-bit x below 65280, where the result fits in 8 bits
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'h0000_8081;
        return prod[30:23];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbo_pipe_ctrl.sv =====
`default_nettype none

module cbo_pipe_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cbo_pkg::NUM_STAGES-1:0]  load
);

    localparam int N = cbo_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] ready;

    // a stage takes a new request when it is empty or its content moves on
    always_comb
    begin
        ready[N-1] = !valid_reg[N-1] || !out_stall;
        for (int k = N - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load      = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/cbo_locate.sv =====
`default_nettype none

module cbo_locate #(
    parameter  int BADGE_W = cbo_pkg::BADGE_W_DEFAULT,
    parameter  int BADGE_H = cbo_pkg::BADGE_H_DEFAULT,
    localparam int DX_W    = $clog2(BADGE_W)
) (
    input  logic                         clk,
    input  logic [1:0]                   load,
    input  logic [cbo_pkg::COORD_W-1:0]  frame_width,
    input  logic [cbo_pkg::COORD_W-1:0]  frame_height,
    input  logic                         skip_badge,
    input  logic [cbo_pkg::COORD_W-1:0]  pixel_x,
    input  logic [cbo_pkg::COORD_W-1:0]  pixel_y,
    output logic [DX_W-1:0]              dx,
    output logic                         in_badge,
    output logic                         in_bar
);

    localparam int EXT_W = cbo_pkg::COORD_W + 1;
    localparam int BAR_Y = BADGE_H / 2 - cbo_pkg::BAR_Y_OFS;

    logic [cbo_pkg::COORD_W-1:0] px_reg;
    logic [cbo_pkg::COORD_W-1:0] py_reg;
    logic [EXT_W-1:0]            x0_reg;
    logic [EXT_W-1:0]            y0_reg;
    logic                        en_reg;
    logic [EXT_W-1:0]            x0_next;
    logic [EXT_W-1:0]            y0_next;
    logic                        en_next;

    logic [EXT_W-1:0]            dxf;
    logic [EXT_W-1:0]            dyf;
    logic                        in_x;
    logic                        in_y;
    logic                        in_row;
    logic                        in_col;
    logic [DX_W-1:0]             dx_reg;
    logic                        in_badge_reg;
    logic                        in_bar_reg;
    logic                        in_badge_next;
    logic                        in_bar_next;

    // badge origin; a borrow means the frame is too small for the badge
    always_comb
    begin
        x0_next = EXT_W'(frame_width)  - EXT_W'(BADGE_W + cbo_pkg::MARGIN);
        y0_next = EXT_W'(frame_height) - EXT_W'(BADGE_H + cbo_pkg::MARGIN);
        en_next = !skip_badge && !x0_next[EXT_W-1] && !y0_next[EXT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            en_reg <= en_next;
        end
    end

    // a pixel left of or above the origin wraps to a large offset
    always_comb
    begin
        dxf    = EXT_W'(px_reg) - x0_reg;
        dyf    = EXT_W'(py_reg) - y0_reg;
        in_x   = dxf < EXT_W'(BADGE_W);
        in_y   = dyf < EXT_W'(BADGE_H);
        in_row = (dyf >= EXT_W'(BAR_Y)) && (dyf < EXT_W'(BAR_Y + cbo_pkg::BAR_H));
        in_col = ((dxf >= EXT_W'(cbo_pkg::BAR0_X))
                     && (dxf < EXT_W'(cbo_pkg::BAR0_X + cbo_pkg::BAR_W)))
              || ((dxf >= EXT_W'(cbo_pkg::BAR1_X))
                     && (dxf < EXT_W'(cbo_pkg::BAR1_X + cbo_pkg::BAR_W)))
              || ((dxf >= EXT_W'(cbo_pkg::BAR2_X))
                     && (dxf < EXT_W'(cbo_pkg::BAR2_X + cbo_pkg::BAR_W)));
        in_badge_next = en_reg && in_x && in_y;
        in_bar_next   = in_badge_next && in_row && in_col;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            dx_reg       <= dxf[DX_W-1:0];
            in_badge_reg <= in_badge_next;
            in_bar_reg   <= in_bar_next;
        end
    end

    assign dx       = dx_reg;
    assign in_badge = in_badge_reg;
    assign in_bar   = in_bar_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cbo_ramp.sv =====
`default_nettype none

module cbo_ramp #(
    parameter  int                          BADGE_W = cbo_pkg::BADGE_W_DEFAULT,
    parameter  logic [cbo_pkg::CHAN_W-1:0]  C_LEFT  = cbo_pkg::RED_LEFT,
    parameter  logic [cbo_pkg::CHAN_W-1:0]  C_RIGHT = cbo_pkg::RED_RIGHT,
    localparam int                          DX_W    = $clog2(BADGE_W)
) (
    input  logic                         clk,
    input  logic [2:0]                   load,
    input  logic [DX_W-1:0]              dx,
    output logic [cbo_pkg::CHAN_W-1:0]   ramp
);

    localparam int NUM_W   = $clog2(255 * BADGE_W + 1);
    localparam int RECIP   = (1 << NUM_W) / BADGE_W;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int CW      = cbo_pkg::CHAN_W;

    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_hold_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CW-1:0]     q_est;
    logic [NUM_W-1:0]  rem;
    logic [CW-1:0]     ramp_next;
    logic [CW-1:0]     ramp_reg;

    always_comb
    begin
        num_next = NUM_W'(C_LEFT) * (NUM_W'(BADGE_W) - NUM_W'(dx))
                 + NUM_W'(C_RIGHT) * NUM_W'(dx);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            num_reg <= num_next;
        end
        if (load[1])
        begin
            prod_reg     <= PROD_W'(num_reg) * PROD_W'(RECIP);
            num_hold_reg <= num_reg;
        end
        if (load[2])
        begin
            ramp_reg <= ramp_next;
        end
    end

    // reciprocal estimate is exact or one low; fix with one compare
    always_comb
    begin
        q_est     = prod_reg[NUM_W +: CW];
        rem       = num_hold_reg - NUM_W'(q_est) * NUM_W'(BADGE_W);
        ramp_next = (rem >= NUM_W'(BADGE_W)) ? q_est + CW'(1) : q_est;
    end

    assign ramp = ramp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cbo_mix.sv =====
`default_nettype none

module cbo_mix #(
    parameter logic [cbo_pkg::CHAN_W-1:0] ALPHA = cbo_pkg::BG_ALPHA
) (
    input  logic                         clk,
    input  logic [1:0]                   load,
    input  logic [cbo_pkg::CHAN_W-1:0]   old_val,
    input  logic [cbo_pkg::CHAN_W-1:0]   new_val,
    output logic [cbo_pkg::CHAN_W-1:0]   mixed
);

    localparam logic [15:0] KEEP = 16'(8'd255 - ALPHA);
    localparam logic [15:0] TAKE = 16'(ALPHA);

    logic [15:0]                 sum_reg;
    logic [cbo_pkg::CHAN_W-1:0]  mixed_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sum_reg <= 16'(old_val) * KEEP + 16'(new_val) * TAKE;
        end
        if (load[1])
        begin
            mixed_reg <= cbo_pkg::div255(sum_reg);
        end
    end

    assign mixed = mixed_reg;

endmodule

`default_nettype wire

// ===== rtl/core/corner_badge_overlay_blender_unit.sv =====
`default_nettype none
// Throughput: one pixel per cycle while out_stall is low; a stall on the output backs up only through
// full stages, so empty stages keep taking input while a result waits.
// Reset (rst_n, async, active low) empties the pipeline and loads
// frame_width 1920, frame_height 1080, skip_badge 0.

module corner_badge_overlay_blender_unit #(
    parameter int BADGE_W = cbo_pkg::BADGE_W_DEFAULT,
    parameter int BADGE_H = cbo_pkg::BADGE_H_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cbo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbo_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cbo_pkg::COORD_W-1:0]     pixel_x,
    input  logic [cbo_pkg::COORD_W-1:0]     pixel_y,
    input  logic [cbo_pkg::CHAN_W-1:0]      in_red,
    input  logic [cbo_pkg::CHAN_W-1:0]      in_green,
    input  logic [cbo_pkg::CHAN_W-1:0]      in_blue,
    input  logic [cbo_pkg::CHAN_W-1:0]      in_alpha,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cbo_pkg::CHAN_W-1:0]      out_red,
    output logic [cbo_pkg::CHAN_W-1:0]      out_green,
    output logic [cbo_pkg::CHAN_W-1:0]      out_blue,
    output logic [cbo_pkg::CHAN_W-1:0]      out_alpha
);

    localparam int N    = cbo_pkg::NUM_STAGES;
    localparam int DX_W = $clog2(BADGE_W);

    logic [cbo_pkg::COORD_W-1:0] frame_width_reg;
    logic [cbo_pkg::COORD_W-1:0] frame_height_reg;
    logic                        skip_badge_reg;

    logic [N-1:0]                load;
    cbo_pkg::side_t              side_reg  [N];
    cbo_pkg::side_t              side_next [N];

    logic [DX_W-1:0]             loc_dx;
    logic                        loc_in_badge;
    logic                        loc_in_bar;
    cbo_pkg::rgb_t               ramp;
    cbo_pkg::rgb_t               mix1;
    cbo_pkg::rgb_t               mix2;
    cbo_pkg::rgb_t               bar_color;
    cbo_pkg::side_t              last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cbo_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= cbo_pkg::FRAME_HEIGHT_RST;
            skip_badge_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cbo_pkg::cfg_index_t'(cfg_index))
                cbo_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                cbo_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                cbo_pkg::CFG_SKIP_BADGE:   skip_badge_reg   <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    cbo_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load)
    );

    cbo_locate #(
        .BADGE_W (BADGE_W),
        .BADGE_H (BADGE_H)
    ) u_locate (
        .clk          (clk),
        .load         (load[cbo_pkg::STG_LOC_B:cbo_pkg::STG_LOC_A]),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .skip_badge   (skip_badge_reg),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .dx           (loc_dx),
        .in_badge     (loc_in_badge),
        .in_bar       (loc_in_bar)
    );

    cbo_ramp #(.BADGE_W(BADGE_W), .C_LEFT(cbo_pkg::RED_LEFT), .C_RIGHT(cbo_pkg::RED_RIGHT))
    u_ramp_red (
        .clk  (clk),
        .load (load[cbo_pkg::STG_RAMP_FIX:cbo_pkg::STG_RAMP_NUM]),
        .dx   (loc_dx),
        .ramp (ramp.red)
    );

    cbo_ramp #(.BADGE_W(BADGE_W), .C_LEFT(cbo_pkg::GRN_LEFT), .C_RIGHT(cbo_pkg::GRN_RIGHT))
    u_ramp_green (
        .clk  (clk),
        .load (load[cbo_pkg::STG_RAMP_FIX:cbo_pkg::STG_RAMP_NUM]),
        .dx   (loc_dx),
        .ramp (ramp.green)
    );

    cbo_ramp #(.BADGE_W(BADGE_W), .C_LEFT(cbo_pkg::BLU_LEFT), .C_RIGHT(cbo_pkg::BLU_RIGHT))
    u_ramp_blue (
        .clk  (clk),
        .load (load[cbo_pkg::STG_RAMP_FIX:cbo_pkg::STG_RAMP_NUM]),
        .dx   (loc_dx),
        .ramp (ramp.blue)
    );

    // side band: original pixel, alpha and badge flags ride along each stage
    always_comb
    begin
        side_next[0].pix.red   = in_red;
        side_next[0].pix.green = in_green;
        side_next[0].pix.blue  = in_blue;
        side_next[0].alpha     = in_alpha;
        side_next[0].in_badge  = 1'b0;
        side_next[0].in_bar    = 1'b0;
        for (int k = 1; k < N; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[cbo_pkg::STG_RAMP_NUM].in_badge = loc_in_badge;
        side_next[cbo_pkg::STG_RAMP_NUM].in_bar   = loc_in_bar;
        // keep the gradient blend only inside the badge
        if (side_reg[cbo_pkg::STG_MIX1_DIV].in_badge)
        begin
            side_next[cbo_pkg::STG_MIX2_SUM].pix = mix1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (load[k])
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    cbo_mix #(.ALPHA(cbo_pkg::BG_ALPHA)) u_mix1_red (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX1_DIV:cbo_pkg::STG_MIX1_SUM]),
        .old_val (side_reg[cbo_pkg::STG_RAMP_FIX].pix.red),
        .new_val (ramp.red),
        .mixed   (mix1.red)
    );

    cbo_mix #(.ALPHA(cbo_pkg::BG_ALPHA)) u_mix1_green (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX1_DIV:cbo_pkg::STG_MIX1_SUM]),
        .old_val (side_reg[cbo_pkg::STG_RAMP_FIX].pix.green),
        .new_val (ramp.green),
        .mixed   (mix1.green)
    );

    cbo_mix #(.ALPHA(cbo_pkg::BG_ALPHA)) u_mix1_blue (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX1_DIV:cbo_pkg::STG_MIX1_SUM]),
        .old_val (side_reg[cbo_pkg::STG_RAMP_FIX].pix.blue),
        .new_val (ramp.blue),
        .mixed   (mix1.blue)
    );

    assign bar_color.red   = cbo_pkg::BAR_RED;
    assign bar_color.green = cbo_pkg::BAR_GRN;
    assign bar_color.blue  = cbo_pkg::BAR_BLU;

    cbo_mix #(.ALPHA(cbo_pkg::BAR_ALPHA)) u_mix2_red (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX2_DIV:cbo_pkg::STG_MIX2_SUM]),
        .old_val (side_next[cbo_pkg::STG_MIX2_SUM].pix.red),
        .new_val (bar_color.red),
        .mixed   (mix2.red)
    );

    cbo_mix #(.ALPHA(cbo_pkg::BAR_ALPHA)) u_mix2_green (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX2_DIV:cbo_pkg::STG_MIX2_SUM]),
        .old_val (side_next[cbo_pkg::STG_MIX2_SUM].pix.green),
        .new_val (bar_color.green),
        .mixed   (mix2.green)
    );

    cbo_mix #(.ALPHA(cbo_pkg::BAR_ALPHA)) u_mix2_blue (
        .clk     (clk),
        .load    (load[cbo_pkg::STG_MIX2_DIV:cbo_pkg::STG_MIX2_SUM]),
        .old_val (side_next[cbo_pkg::STG_MIX2_SUM].pix.blue),
        .new_val (bar_color.blue),
        .mixed   (mix2.blue)
    );

    assign last      = side_reg[N-1];
    assign out_red   = last.in_bar ? mix2.red   : last.pix.red;
    assign out_green = last.in_bar ? mix2.green : last.pix.green;
    assign out_blue  = last.in_bar ? mix2.blue  : last.pix.blue;
    assign out_alpha = last.alpha;

endmodule

`default_nettype wire

// ===== rtl/core/cbo_checker.sv =====
`default_nettype none

module cbo_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [cbo_pkg::CHAN_W-1:0]  in_alpha,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [cbo_pkg::CHAN_W-1:0]  out_alpha
);

    localparam int LAT  = cbo_pkg::NUM_STAGES;
    localparam int HOPS = LAT - 1;

    logic quiet;
    logic taken;

    assign quiet = rst_n && !out_stall;
    assign taken = rst_n && in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side can move");

    // a request taken with no output stall on the following edges shows up on the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        taken ##1 quiet [*HOPS] |=> out_valid)
        else $error("result missing after pipeline latency");

    a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
        taken ##1 quiet [*HOPS] |=> out_alpha == $past(in_alpha, LAT))
        else $error("alpha not passed through");

endmodule

bind corner_badge_overlay_blender_unit cbo_checker u_cbo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_alpha (out_alpha)
);

`default_nettype wire

// ===== verif/overlay_checker.sv =====
`default_nettype none

module overlay_checker
    import cbo_pkg::*;
#(
    parameter int BADGE_W = BADGE_W_DEFAULT,
    parameter int BADGE_H = BADGE_H_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [COORD_W-1:0]   pixel_x,
    input  wire logic [COORD_W-1:0]   pixel_y,
    input  wire logic [CHAN_W-1:0]    in_red,
    input  wire logic [CHAN_W-1:0]    in_green,
    input  wire logic [CHAN_W-1:0]    in_blue,
    input  wire logic [CHAN_W-1:0]    in_alpha,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [CHAN_W-1:0]    out_red,
    input  wire logic [CHAN_W-1:0]    out_green,
    input  wire logic [CHAN_W-1:0]    out_blue,
    input  wire logic [CHAN_W-1:0]    out_alpha,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } color_t;

    logic [COORD_W-1:0] width_cfg;
    logic [COORD_W-1:0] height_cfg;
    bit                 skip_cfg;
    color_t             expected_px[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [CHAN_W-1:0] blend(int unsigned old_c, int unsigned new_c,
                                                 int unsigned a);
        return CHAN_W'((old_c * (255 - a) + new_c * a) / 255);
    endfunction

    function automatic int unsigned gradient(int unsigned left_c, int unsigned right_c,
                                             int unsigned dx);
        return (left_c * (BADGE_W - dx) + right_c * dx) / BADGE_W;
    endfunction

    function automatic color_t overlay_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                             color_t c);
        color_t o;
        int     x0;
        int     y0;
        int     dx;
        int     dy;
        int     bar_top;
        bit     in_rows;
        bit     in_cols;
        o = c;
        if (!skip_cfg && int'(width_cfg) >= BADGE_W + MARGIN
            && int'(height_cfg) >= BADGE_H + MARGIN)
        begin
            x0 = int'(width_cfg) - BADGE_W - MARGIN;
            y0 = int'(height_cfg) - BADGE_H - MARGIN;
            dx = int'(px) - x0;
            dy = int'(py) - y0;
            if (dx >= 0 && dx < BADGE_W && dy >= 0 && dy < BADGE_H)
            begin
                o.red   = blend(c.red,   gradient(RED_LEFT, RED_RIGHT, dx), BG_ALPHA);
                o.green = blend(c.green, gradient(GRN_LEFT, GRN_RIGHT, dx), BG_ALPHA);
                o.blue  = blend(c.blue,  gradient(BLU_LEFT, BLU_RIGHT, dx), BG_ALPHA);
                bar_top = BADGE_H / 2 - BAR_Y_OFS;
                in_rows = dy >= bar_top && dy < bar_top + BAR_H;
                in_cols = (dx >= BAR0_X && dx < BAR0_X + BAR_W)
                       || (dx >= BAR1_X && dx < BAR1_X + BAR_W)
                       || (dx >= BAR2_X && dx < BAR2_X + BAR_W);
                if (in_rows && in_cols)
                begin
                    o.red   = blend(o.red,   BAR_RED, BAR_ALPHA);
                    o.green = blend(o.green, BAR_GRN, BAR_ALPHA);
                    o.blue  = blend(o.blue,  BAR_BLU, BAR_ALPHA);
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        color_t got;
        color_t src;
        if (!rst_n)
        begin
            width_cfg  = FRAME_WIDTH_RST;
            height_cfg = FRAME_HEIGHT_RST;
            skip_cfg   = 1'b0;
            expected_px.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_cfg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_cfg = cfg_data;
                    CFG_SKIP_BADGE:   skip_cfg   = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = '{out_red, out_green, out_blue, out_alpha};
                if (expected_px.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no request outstanding", got));
                end
                else
                begin
                    want = expected_px.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red got %0d want %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d want %0d",
                                                  got.blue, want.blue));
                    if (got.alpha !== want.alpha)
                        report_mismatch($sformatf("alpha got %0d want %0d",
                                                  got.alpha, want.alpha));
                end
            end
            if (in_valid && !in_stall)
            begin
                src = '{in_red, in_green, in_blue, in_alpha};
                expected_px.push_back(overlay_pixel(pixel_x, pixel_y, src));
            end
            pending = expected_px.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;

    import cbo_pkg::*;

    localparam int BW = BADGE_W_DEFAULT;
    localparam int BH = BADGE_H_DEFAULT;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_W-1:0]    pixel_x = '0;
    logic [COORD_W-1:0]    pixel_y = '0;
    logic [CHAN_W-1:0]     in_red = '0;
    logic [CHAN_W-1:0]     in_green = '0;
    logic [CHAN_W-1:0]     in_blue = '0;
    logic [CHAN_W-1:0]     in_alpha = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [CHAN_W-1:0]     out_alpha;

    int fail_count;
    int pending;

    int cur_w = 1920;
    int cur_h = 1080;
    bit squeeze_go = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    corner_badge_overlay_blender_unit #(.BADGE_W(BW), .BADGE_H(BH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    overlay_checker #(.BADGE_W(BW), .BADGE_H(BH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // output side back-pressure
    int  hold_left = 0;
    int  open_left = 0;
    bit  squeeze_done = 1'b0;
    int  stall_roll;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (squeeze_go && !squeeze_done)
        begin
            // long hold so the pipeline fills and stalls its input
            squeeze_done = 1'b1;
            hold_left = 119;
            out_stall <= 1'b1;
        end
        else if (open_left > 0)
        begin
            open_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60)
            begin
                out_stall <= 1'b0;
            end
            else if (stall_roll < 63)
            begin
                open_left = $urandom_range(20, 60);
                out_stall <= 1'b0;
            end
            else if (stall_roll < 95)
            begin
                hold_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                hold_left = $urandom_range(8, 30);
                out_stall <= 1'b1;
            end
        end
    end

    function automatic int gap_cycles(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CHAN_W-1:0] channel_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    // call at a rising edge; returns at the edge that took the request, or after the idle gap that follows it
    task automatic send_pixel(int x, int y, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a, bit burst);
        bit taken;
        int gap;
        in_valid <= 1'b1;
        pixel_x  <= COORD_W'(x);
        pixel_y  <= COORD_W'(y);
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        in_alpha <= a;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        gap = gap_cycles(burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(bit burst);
        int x;
        int y;
        if ($urandom_range(0, 9) < 7)
        begin
            // aim around the badge rectangle, edges included
            x = cur_w - BW - 16 + int'($urandom_range(0, BW + 7)) - 4;
            y = cur_h - BH - 16 + int'($urandom_range(0, BH + 7)) - 4;
        end
        else
        begin
            x = $urandom_range(0, 8191);
            y = $urandom_range(0, 8191);
        end
        send_pixel(x, y, channel_value(), channel_value(), channel_value(),
                   CHAN_W'($urandom_range(0, 255)), burst);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic program_frame(int w, int h, bit skip);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= CFG_SKIP_BADGE;
        cfg_data  <= CFG_DATA_W'(skip);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic run_phase(int w, int h, bit skip, int count, bit burst, bit squeeze);
        drain();
        program_frame(w, h, skip);
        if (squeeze)
            squeeze_go <= 1'b1;
        repeat (count) send_random(burst);
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int x0;
        int y0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: badge at 1832..1903, 1032..1063, bars on rows 10..21
        x0 = 1920 - BW - 16;
        y0 = 1080 - BH - 16;
        send_pixel(0, 0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8191, 8191, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(x0, y0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(x0, y0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(x0 + BW - 1, y0 + BH - 1, 8'd255, 8'd0, 8'd255, 8'd128, 1'b0);
        send_pixel(x0 - 1, y0 + 8, 8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
        send_pixel(x0 + BW, y0 + 8, 8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
        send_pixel(x0 + 18, y0 - 1, 8'd90, 8'd90, 8'd90, 8'd1, 1'b0);
        send_pixel(x0 + 18, y0 + BH, 8'd90, 8'd90, 8'd90, 8'd2, 1'b1);
        send_pixel(x0 + 18, y0 + 10, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(x0 + 23, y0 + 21, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        send_pixel(x0 + 24, y0 + 15, 8'd128, 8'd64, 8'd32, 8'd16, 1'b1);
        send_pixel(x0 + 34, y0 + 15, 8'd128, 8'd64, 8'd32, 8'd16, 1'b0);
        send_pixel(x0 + 39, y0 + 15, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0);
        send_pixel(x0 + 50, y0 + 15, 8'd200, 8'd100, 8'd50, 8'd25, 1'b0);
        send_pixel(x0 + 55, y0 + 15, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(x0 + 56, y0 + 15, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(x0 + 20, y0 + 9, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(x0 + 20, y0 + 22, 8'd170, 8'd85, 8'd170, 8'd85, 1'b0);
        send_pixel(8191, y0 + 10, 8'd170, 8'd85, 8'd170, 8'd85, 1'b0);
        send_pixel(x0 + 20, 8191, 8'd85, 8'd170, 8'd85, 8'd170, 1'b0);
        send_pixel(4095, 4096, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        send_pixel(1919, 1079, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        in_valid <= 1'b0;

        run_phase(1920, 1080, 1'b0, 90, 1'b0, 1'b0);
        run_phase(BW + 16, BH + 16, 1'b0, 60, 1'b0, 1'b0);
        run_phase(8191, 8191, 1'b0, 70, 1'b1, 1'b0);
        run_phase(BW + 15, BH + 16, 1'b0, 30, 1'b0, 1'b0);
        run_phase(BW + 16, BH + 15, 1'b0, 30, 1'b0, 1'b0);
        run_phase(0, 0, 1'b0, 20, 1'b0, 1'b0);
        run_phase(1920, 1080, 1'b1, 40, 1'b0, 1'b0);
        run_phase($urandom_range(BW + 16, 8191), $urandom_range(BH + 16, 8191), 1'b0,
                  80, 1'b1, 1'b1);
        run_phase($urandom_range(0, 8191), $urandom_range(0, 8191), 1'($urandom_range(0, 1)),
                  50, 1'b0, 1'b0);

        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
